/* hdl/mie_pkg.sv */
// Package for the modular inverse block: command and status types shared by
// the controller, the datapath and the top level. No dependencies.
`default_nettype none

package mie_pkg;

  // Commands from the controller to the datapath, at most a few active at once.
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_sel_mod;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic update;
    logic emit;
    logic emit_ok;
  } mie_cmd_t;

  // Status the controller needs to steer the Euclid loop.
  typedef struct packed {
    logic m_zero;
    logic b_zero;
    logic a_one;
  } mie_status_t;

endpackage

`default_nettype wire

/* hdl/mie_if.sv */
// Valid/ready channel interfaces for the modular inverse block.
// No dependencies; the operand channel and the result channel each get one.
`default_nettype none

interface mie_in_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface mie_out_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] inverse;
  logic             valid_res;

  modport source (output valid, output inverse, output valid_res, input ready);
  modport sink   (input valid, input inverse, input valid_res, output ready);
endinterface

`default_nettype wire

/* hdl/mie_datapath.sv */
// Datapath of the modular inverse block: Euclid operands, coefficients, a
// bit-serial restoring divider, a shift-add multiplier and the result register.
// Depends on mie_pkg for the command and status types.
`default_nettype none

module mie_datapath
  import mie_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire mie_cmd_t         cmd,
  output mie_status_t           status,
  input  wire logic [WIDTH-1:0] value,
  input  wire logic [WIDTH-1:0] modulus,
  output logic      [WIDTH-1:0] inverse,
  output logic                  valid_res
);

  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] ma;
  logic [WIDTH-1:0] mb;
  logic             nega;

  // Divider: quotient shifts in at the bottom of dq as the dividend shifts out.
  logic [WIDTH-1:0] dq;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dv;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // Multiplier: acc starts at ma, so it ends holding ma + q * mb modulo 2^WIDTH.
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] mcand;
  logic [WIDTH-1:0] mplier;

  assign trial = {rem, dq[WIDTH-1]};
  assign diff  = trial - {1'b0, dv};

  assign status.m_zero = (m == '0);
  assign status.b_zero = (b == '0);
  assign status.a_one  = (a == WIDTH'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a    <= modulus;
      b    <= value;
      m    <= modulus;
      ma   <= '0;
      mb   <= WIDTH'(1);
      nega <= 1'b1;
    end else if (cmd.update) begin
      a    <= b;
      b    <= rem;
      ma   <= mb;
      mb   <= acc;
      nega <= ~nega;
    end

    if (cmd.div_init) begin
      rem <= '0;
      if (cmd.div_sel_mod) begin
        dq <= ma;
        dv <= m;
      end else begin
        dq <= a;
        dv <= b;
      end
    end else if (cmd.div_step) begin
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
        dq  <= {dq[WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[WIDTH-1:0];
        dq  <= {dq[WIDTH-2:0], 1'b0};
      end
    end

    if (cmd.mul_init) begin
      acc    <= ma;
      mcand  <= mb;
      mplier <= dq;
    end else if (cmd.mul_step) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[WIDTH-2:0], 1'b0};
      mplier <= {1'b0, mplier[WIDTH-1:1]};
    end

    if (cmd.emit) begin
      if (cmd.emit_ok) begin
        // A negative coefficient is folded back into [0, modulus).
        if (nega && (rem != '0)) begin
          inverse <= m - rem;
        end else begin
          inverse <= rem;
        end
        valid_res <= 1'b1;
      end else begin
        inverse   <= '0;
        valid_res <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/mie_controller.sv */
// Controller of the modular inverse block: sequences load, divide, multiply,
// update, final reduction and result transfer. Depends on mie_pkg.
`default_nettype none

module mie_controller
  import mie_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mie_cmd_t         cmd,
  input  wire mie_status_t status
);

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MULI,
    S_MUL,
    S_UPD,
    S_MOD,
    S_FIN
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic            ok;
  logic            last;

  assign last = (cnt == CW'(WIDTH - 1));

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: begin
        if (!status.m_zero) begin
          if (status.b_zero) begin
            cmd.div_init    = status.a_one;
            cmd.div_sel_mod = 1'b1;
          end else begin
            cmd.div_init = 1'b1;
          end
        end
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_MULI:  cmd.mul_init = 1'b1;
      S_MUL:   cmd.mul_step = 1'b1;
      S_UPD:   cmd.update   = 1'b1;
      S_MOD:   cmd.div_step = 1'b1;
      S_FIN: begin
        cmd.emit    = !out_valid || out_ready;
        cmd.emit_ok = ok;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ok        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt <= '0;
          if (status.m_zero) begin
            ok    <= 1'b0;
            state <= S_FIN;
          end else if (status.b_zero) begin
            // The remainder sequence has ended; a is the gcd.
            ok    <= status.a_one;
            state <= status.a_one ? S_MOD : S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            state <= S_MULI;
          end
        end
        S_MULI: begin
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            state <= S_UPD;
          end
        end
        S_UPD: state <= S_CHECK;
        S_MOD: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (cmd.emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted operands did not start a check");

  a_div_to_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && last) |=> (state == S_MULI))
    else $error("divide did not hand over to multiply");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result is not presented");

  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("result overwritten while still held");

endmodule

`default_nettype wire

/* hdl/modular_inverse_ext_euclid.sv */
// Modular inverse by the extended Euclidean algorithm.
// The operand channel carries value and modulus; the result channel carries
// inverse, in [0, modulus), and valid_res, set when gcd(value, modulus) is 1.
// When no inverse exists, or the modulus is zero, inverse is 0 and valid_res
// is 0. A modulus of one gives inverse 0 with valid_res set.
// One pair is worked on at a time: operands are accepted only while the
// controller is idle. Each Euclid iteration runs a check, the bit-serial
// divider, a multiplier load, the shift-add multiplier and an update. The
// final reduction of the coefficient reuses the divider before the result
// is emitted. For 32-bit operands the loop runs at most about 47 iterations.
// The result sits in an output register, so the next operand pair is accepted
// while a result still waits to be taken; a stalled receiver only holds the
// block once its next result is ready. Reset empties the output register and
// returns the controller to idle.
`default_nettype none

module modular_inverse_ext_euclid
  import mie_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  mie_in_if.sink    operands,
  mie_out_if.source result
);

  mie_cmd_t    cmd;
  mie_status_t status;

  mie_controller #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  mie_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .status    (status),
    .value     (operands.value),
    .modulus   (operands.modulus),
    .inverse   (result.inverse),
    .valid_res (result.valid_res)
  );

endmodule

`default_nettype wire
